// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the training step unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked outside reset
`define SOM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every edge, reset included
`define SOM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SOM_ASSERT(label, prop, msg)
`define SOM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: hdl/som_pkg.sv
// ----------------------------------------------------------------------------
// SOM training package
// Shared widths, codes and reset values of the self-organizing map unit.
// ----------------------------------------------------------------------------
package som_pkg;
   localparam int FRAC_BITS     = 16;
   localparam int VAL_W         = 16;
   localparam int DIST_W        = 33;
   localparam int OP_W          = 2;
   localparam int ADDR_FIELD_W  = 4;
   localparam int CSR_IDX_W     = 1;
   localparam int GRID_ROWS_DEF = 10;
   localparam int GRID_COLS_DEF = 10;

   localparam logic [VAL_W-1:0] VAL_MASK    = {VAL_W{1'b1}};
   localparam logic [VAL_W-1:0] LR_RESET    = 16'd13107;
   localparam logic [VAL_W-1:0] DECAY_RESET = 16'd30003;

   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_WRITE = 2'd0;
   localparam op_type OP_READ  = 2'd1;
   localparam op_type OP_TRAIN = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_LEARNING_RATE   = 1'd0;
   localparam csr_idx_type CSR_NEIGHBOUR_DECAY = 1'd1;
endpackage

// File: hdl/som_ifs.sv
// ----------------------------------------------------------------------------
// SOM channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface som_req_if
   import som_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic [ADDR_FIELD_W-1:0] row;
   logic [ADDR_FIELD_W-1:0] col;
   logic [VAL_W-1:0]        first_component;
   logic [VAL_W-1:0]        second_component;
   modport source (output valid, operation, row, col, first_component, second_component,
                   input ready);
   modport sink   (input valid, operation, row, col, first_component, second_component,
                   output ready);
endinterface

interface som_rsp_if
   import som_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [ADDR_FIELD_W-1:0] winner_row;
   logic [ADDR_FIELD_W-1:0] winner_col;
   logic [DIST_W-1:0]       min_distance;
   logic [VAL_W-1:0]        read_first;
   logic [VAL_W-1:0]        read_second;
   modport source (output valid, winner_row, winner_col, min_distance, read_first,
                   read_second, input ready);
   modport sink   (input valid, winner_row, winner_col, min_distance, read_first,
                   read_second, output ready);
endinterface

// File: hdl/som_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module som_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/som_dist.sv
// ----------------------------------------------------------------------------
// SOM distance stage
// Registered squared Euclidean distance between a weight and the sample.
// ----------------------------------------------------------------------------
module som_dist
   import som_pkg::*;
(
   input  logic                 clock,
   input  logic [VAL_W-1:0]     x0,
   input  logic [VAL_W-1:0]     x1,
   input  logic [2*VAL_W-1:0]   weight,
   output logic [DIST_W-1:0]    sq_dist
);
   logic [VAL_W-1:0]   d0, d1, w0, w1;
   logic [2*VAL_W-1:0] sq0, sq1;
   logic [DIST_W-1:0]  dist_ff;

   always_comb begin
      w0  = weight[VAL_W-1:0];
      w1  = weight[2*VAL_W-1:VAL_W];
      d0  = (x0 >= w0) ? (x0 - w0) : (w0 - x0);
      d1  = (x1 >= w1) ? (x1 - w1) : (w1 - x1);
      sq0 = (2*VAL_W)'(d0) * (2*VAL_W)'(d0);
      sq1 = (2*VAL_W)'(d1) * (2*VAL_W)'(d1);
   end

   always_ff @(posedge clock) begin
      dist_ff <= DIST_W'(sq0) + DIST_W'(sq1);
   end

   assign sq_dist = dist_ff;
endmodule

// File: hdl/som_move.sv
// ----------------------------------------------------------------------------
// SOM weight update stage
// Moves both weight components toward the sample by coef, rounding down.
// ----------------------------------------------------------------------------
module som_move
   import som_pkg::*;
(
   input  logic               clock,
   input  logic [VAL_W-1:0]   x0,
   input  logic [VAL_W-1:0]   x1,
   input  logic [VAL_W-1:0]   coef,
   input  logic [2*VAL_W-1:0] weight,
   output logic [2*VAL_W-1:0] weight_new
);
   logic [VAL_W-1:0]   xs   [2];
   logic [VAL_W-1:0]   ws   [2];
   logic [VAL_W-1:0]   diff [2];
   logic [2*VAL_W-1:0] mag  [2];
   logic [2*VAL_W:0]   down [2];
   logic [VAL_W-1:0]   nw   [2];
   logic [2*VAL_W-1:0] weight_new_ff;

   always_comb begin
      xs[0] = x0;
      xs[1] = x1;
      ws[0] = weight[VAL_W-1:0];
      ws[1] = weight[2*VAL_W-1:VAL_W];
      for (int k = 0; k < 2; k++) begin
         diff[k] = (xs[k] >= ws[k]) ? (xs[k] - ws[k]) : (ws[k] - xs[k]);
         mag[k]  = (2*VAL_W)'(diff[k]) * (2*VAL_W)'(coef);
         // round the downward step up so the result floors
         down[k] = ((2*VAL_W+1)'(mag[k]) + (2*VAL_W+1)'(VAL_MASK)) >> FRAC_BITS;
         if (xs[k] >= ws[k]) begin
            nw[k] = ws[k] + mag[k][2*VAL_W-1:FRAC_BITS];
         end else begin
            nw[k] = ws[k] - down[k][VAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      weight_new_ff <= {nw[1], nw[0]};
   end

   assign weight_new = weight_new_ff;
endmodule

// File: hdl/som_training_step_unit.sv
// ----------------------------------------------------------------------------
// SOM training step unit
// Kohonen map with weights in RAM: write, read and train transactions.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one transaction: operation (write, read, train), row/col
//   of the neuron and two Q0.16 components (weight or sample). rsp_if returns
//   exactly one transaction per request: winner and distance on train, the
//   stored weight on read, zeros otherwise.
//   csr_* writes learning_rate (index 0) and neighbour_decay (index 1). The
//   user must write them while the unit is idle; it is not enforced.
//   Train builds the coefficient table of TD = (GRID_ROWS-1)^2 +
//   (GRID_COLS-1)^2 + 1 gain entries (one entry per cycle), then makes
//   two sweeps over the N = GRID_ROWS*GRID_COLS neurons through the
//   single weight RAM read port: winner search, then weight update.
//   One request is in work at a time; a new request is taken once the
//   previous response sits in the output register, even if rsp_if stalls.
//   Reset is synchronous: state, valid flags and rate registers return to
//   defaults, weights are undefined until written. A stalled response
//   holds its payload.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module som_training_step_unit
   import som_pkg::*;
#(
   parameter int GRID_ROWS = GRID_ROWS_DEF,
   parameter int GRID_COLS = GRID_COLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   som_req_if.sink              req_if,
   som_rsp_if.source            rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_wr_data
);
   localparam int N     = GRID_ROWS * GRID_COLS;
   localparam int AW    = $clog2(N);
   localparam int CNT_W = $clog2(N + 1);
   localparam int RW    = $clog2(GRID_ROWS);
   localparam int KW    = $clog2(GRID_COLS);
   localparam int TD    = (GRID_ROWS - 1) * (GRID_ROWS - 1)
                        + (GRID_COLS - 1) * (GRID_COLS - 1) + 1;
   localparam int TW    = $clog2(TD);
   localparam int TCW   = $clog2(TD + 1);
   localparam int NW    = 2 * RW + 2 * KW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD_WAIT, ST_TBL, ST_SEARCH, ST_UPDATE, ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [VAL_W-1:0]   lr_ff, lr_in, decay_ff, decay_in;
   logic [VAL_W-1:0]   x0_ff, x0_in, x1_ff, x1_in;
   logic               grid_ok_ff, grid_ok_in;
   logic [CNT_W-1:0]   icnt_ff, icnt_in;
   logic [RW-1:0]      irow_ff, irow_in;
   logic [KW-1:0]      icol_ff, icol_in;
   logic [TCW-1:0]     tcnt_ff, tcnt_in;
   logic [FRAC_BITS:0] gain_ff, gain_in;
   logic               s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic [RW-1:0]      s1_row_ff, s1_row_in, s2_row_ff, s2_row_in;
   logic [KW-1:0]      s1_col_ff, s1_col_in, s2_col_ff, s2_col_in;
   logic               have_ff, have_in;
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [RW-1:0]      wrow_ff, wrow_in;
   logic [KW-1:0]      wcol_ff, wcol_in;
   logic               u1_v_ff, u1_v_in, u2_v_ff, u2_v_in;
   logic [AW-1:0]      u1_addr_ff, u1_addr_in, u2_addr_ff, u2_addr_in;
   logic [VAL_W-1:0]   rd0_ff, rd0_in, rd1_ff, rd1_in;
   logic               rsp_v_ff, rsp_v_in;
   logic [ADDR_FIELD_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [VAL_W-1:0]   rsp_rd0_ff, rsp_rd0_in, rsp_rd1_ff, rsp_rd1_in;

   logic               req_fire, req_in_grid, issue_ok;
   logic [AW-1:0]      req_addr;
   logic               wram_we, cram_we;
   logic [AW-1:0]      wram_waddr, wram_raddr;
   logic [2*VAL_W-1:0] wram_wdata, wram_rdata, move_w;
   logic [TW-1:0]      cram_raddr;
   logic [VAL_W-1:0]   cram_wdata, cram_rdata;
   logic [DIST_W-1:0]  sq_dist;
   logic [RW-1:0]      dr;
   logic [KW-1:0]      dc;
   logic [NW-1:0]      norm_full;
   logic [2*FRAC_BITS:0] gain_prod, coef_prod;

   som_ram #(.WIDTH(2*VAL_W), .DEPTH(N)) u_weight_ram (
      .clock   (clock),
      .wr_en   (wram_we),
      .wr_addr (wram_waddr),
      .wr_data (wram_wdata),
      .rd_addr (wram_raddr),
      .rd_data (wram_rdata)
   );

   som_ram #(.WIDTH(VAL_W), .DEPTH(TD)) u_coef_ram (
      .clock   (clock),
      .wr_en   (cram_we),
      .wr_addr (tcnt_ff[TW-1:0]),
      .wr_data (cram_wdata),
      .rd_addr (cram_raddr),
      .rd_data (cram_rdata)
   );

   som_dist u_dist (
      .clock   (clock),
      .x0      (x0_ff),
      .x1      (x1_ff),
      .weight  (wram_rdata),
      .sq_dist (sq_dist)
   );

   som_move u_move (
      .clock      (clock),
      .x0         (x0_ff),
      .x1         (x1_ff),
      .coef       (cram_rdata),
      .weight     (wram_rdata),
      .weight_new (move_w)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign req_in_grid  = (32'(req_if.row) < GRID_ROWS) && (32'(req_if.col) < GRID_COLS);
   assign req_addr     = AW'(int'(req_if.row) * GRID_COLS + int'(req_if.col));
   assign issue_ok     = (icnt_ff < CNT_W'(N));

   // squared grid distance of the issued neuron to the winner
   always_comb begin
      dr = (wrow_ff >= irow_ff) ? (wrow_ff - irow_ff) : (irow_ff - wrow_ff);
      dc = (wcol_ff >= icol_ff) ? (wcol_ff - icol_ff) : (icol_ff - wcol_ff);
      norm_full = NW'((2*RW)'(dr) * (2*RW)'(dr)) + NW'((2*KW)'(dc) * (2*KW)'(dc));
      cram_raddr = norm_full[TW-1:0];
      gain_prod = (2*FRAC_BITS+1)'(gain_ff) * (2*FRAC_BITS+1)'(decay_ff);
      coef_prod = (2*FRAC_BITS+1)'(gain_ff) * (2*FRAC_BITS+1)'(lr_ff);
      cram_wdata = coef_prod[2*FRAC_BITS-1:FRAC_BITS];
   end

   always_comb begin
      state_in   = state_ff;
      lr_in      = lr_ff;
      decay_in   = decay_ff;
      x0_in      = x0_ff;
      x1_in      = x1_ff;
      grid_ok_in = grid_ok_ff;
      icnt_in    = icnt_ff;
      irow_in    = irow_ff;
      icol_in    = icol_ff;
      tcnt_in    = tcnt_ff;
      gain_in    = gain_ff;
      s1_v_in    = 1'b0;
      s1_row_in  = irow_ff;
      s1_col_in  = icol_ff;
      s2_v_in    = s1_v_ff;
      s2_row_in  = s1_row_ff;
      s2_col_in  = s1_col_ff;
      have_in    = have_ff;
      best_in    = best_ff;
      wrow_in    = wrow_ff;
      wcol_in    = wcol_ff;
      u1_v_in    = 1'b0;
      u1_addr_in = icnt_ff[AW-1:0];
      u2_v_in    = u1_v_ff;
      u2_addr_in = u1_addr_ff;
      rd0_in     = rd0_ff;
      rd1_in     = rd1_ff;
      wram_we    = u2_v_ff;
      wram_waddr = u2_addr_ff;
      wram_wdata = move_w;
      wram_raddr = icnt_ff[AW-1:0];
      cram_we    = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEARNING_RATE:   lr_in    = csr_wr_data;
            CSR_NEIGHBOUR_DECAY: decay_in = csr_wr_data;
            default: ;
         endcase
      end

      // first minimum wins: replace only on strictly smaller distance
      if (s2_v_ff && (!have_ff || (sq_dist < best_ff))) begin
         have_in = 1'b1;
         best_in = sq_dist;
         wrow_in = s2_row_ff;
         wcol_in = s2_col_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            wram_raddr = req_addr;
            if (req_fire) begin
               x0_in      = req_if.first_component;
               x1_in      = req_if.second_component;
               grid_ok_in = req_in_grid;
               have_in    = 1'b0;
               best_in    = '0;
               wrow_in    = '0;
               wcol_in    = '0;
               rd0_in     = '0;
               rd1_in     = '0;
               unique case (req_if.operation)
                  OP_WRITE: begin
                     wram_we    = req_in_grid;
                     wram_waddr = req_addr;
                     wram_wdata = {req_if.second_component, req_if.first_component};
                     state_in   = ST_DONE;
                  end
                  OP_READ: state_in = ST_RD_WAIT;
                  OP_TRAIN: begin
                     tcnt_in  = '0;
                     gain_in  = (FRAC_BITS+1)'(1) << FRAC_BITS;
                     state_in = ST_TBL;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_RD_WAIT: begin
            if (grid_ok_ff) begin
               rd0_in = wram_rdata[VAL_W-1:0];
               rd1_in = wram_rdata[2*VAL_W-1:VAL_W];
            end
            state_in = ST_DONE;
         end
         ST_TBL: begin
            // one coefficient per squared grid distance
            cram_we = 1'b1;
            gain_in = gain_prod[2*FRAC_BITS:FRAC_BITS];
            tcnt_in = tcnt_ff + 1'b1;
            if (tcnt_ff == TCW'(TD - 1)) begin
               icnt_in  = '0;
               irow_in  = '0;
               icol_in  = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (issue_ok) begin
               s1_v_in = 1'b1;
               icnt_in = icnt_ff + 1'b1;
               if (icol_ff == KW'(GRID_COLS - 1)) begin
                  icol_in = '0;
                  irow_in = irow_ff + 1'b1;
               end else begin
                  icol_in = icol_ff + 1'b1;
               end
            end else if (!s1_v_ff && !s2_v_ff) begin
               icnt_in  = '0;
               irow_in  = '0;
               icol_in  = '0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (issue_ok) begin
               u1_v_in = 1'b1;
               icnt_in = icnt_ff + 1'b1;
               if (icol_ff == KW'(GRID_COLS - 1)) begin
                  icol_in = '0;
                  irow_in = irow_ff + 1'b1;
               end else begin
                  icol_in = icol_ff + 1'b1;
               end
            end else if (!u1_v_ff && !u2_v_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_v_ff || rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // output register: load when the slot is free, drop once taken
      rsp_row_in  = rsp_row_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_rd0_in  = rsp_rd0_ff;
      rsp_rd1_in  = rsp_rd1_ff;
      rsp_v_in    = rsp_v_ff && !rsp_if.ready;
      if ((state_ff == ST_DONE) && (!rsp_v_ff || rsp_if.ready)) begin
         rsp_v_in    = 1'b1;
         rsp_row_in  = ADDR_FIELD_W'(wrow_ff);
         rsp_col_in  = ADDR_FIELD_W'(wcol_ff);
         rsp_dist_in = best_ff;
         rsp_rd0_in  = rd0_ff;
         rsp_rd1_in  = rd1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lr_ff    <= LR_RESET;
         decay_ff <= DECAY_RESET;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         u1_v_ff  <= 1'b0;
         u2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lr_ff    <= lr_in;
         decay_ff <= decay_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         u1_v_ff  <= u1_v_in;
         u2_v_ff  <= u2_v_in;
         rsp_v_ff <= rsp_v_in;
      end
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      grid_ok_ff  <= grid_ok_in;
      icnt_ff     <= icnt_in;
      irow_ff     <= irow_in;
      icol_ff     <= icol_in;
      tcnt_ff     <= tcnt_in;
      gain_ff     <= gain_in;
      s1_row_ff   <= s1_row_in;
      s1_col_ff   <= s1_col_in;
      s2_row_ff   <= s2_row_in;
      s2_col_ff   <= s2_col_in;
      have_ff     <= have_in;
      best_ff     <= best_in;
      wrow_ff     <= wrow_in;
      wcol_ff     <= wcol_in;
      u1_addr_ff  <= u1_addr_in;
      u2_addr_ff  <= u2_addr_in;
      rd0_ff      <= rd0_in;
      rd1_ff      <= rd1_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_rd0_ff  <= rsp_rd0_in;
      rsp_rd1_ff  <= rsp_rd1_in;
   end

   assign rsp_if.valid        = rsp_v_ff;
   assign rsp_if.winner_row   = rsp_row_ff;
   assign rsp_if.winner_col   = rsp_col_ff;
   assign rsp_if.min_distance = rsp_dist_ff;
   assign rsp_if.read_first   = rsp_rd0_ff;
   assign rsp_if.read_second  = rsp_rd1_ff;

   `SOM_ASSERT(a_idle_drained, (state_ff == ST_IDLE) |-> !(s1_v_ff || s2_v_ff || u1_v_ff || u2_v_ff), "pipeline busy while idle")
   `SOM_ASSERT(a_no_write_in_search, (state_ff == ST_SEARCH) |-> !wram_we, "weight write during winner search")
   `SOM_ASSERT(a_winner_in_grid, rsp_if.valid |-> (32'(rsp_if.winner_row) < GRID_ROWS), "winner row outside grid")
endmodule

// File: verif/som_training_step_unit_test.sv
// ----------------------------------------------------------------------------
// SOM training step unit testbench
// Drives write, read, train and unused-op transactions with random bursts and
// response stalls, predicts every response from a local copy of the weight
// grid and the two rate registers, and compares each response field by field.
// ----------------------------------------------------------------------------
module som_training_step_unit_test;
   import som_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS = GRID_ROWS_DEF;
   localparam int COLS = GRID_COLS_DEF;
   localparam int NEURONS = ROWS * COLS;
   localparam int TRAIN_CYCLES = 372;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      op_type                  operation;
      logic [ADDR_FIELD_W-1:0] row;
      logic [ADDR_FIELD_W-1:0] col;
      logic [VAL_W-1:0]        first_component;
      logic [VAL_W-1:0]        second_component;
   } request_type;

   typedef struct packed {
      logic [ADDR_FIELD_W-1:0] winner_row;
      logic [ADDR_FIELD_W-1:0] winner_col;
      logic [DIST_W-1:0]       min_distance;
      logic [VAL_W-1:0]        read_first;
      logic [VAL_W-1:0]        read_second;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VAL_W-1:0]     csr_wr_data = '0;

   som_req_if req_if ();
   som_rsp_if rsp_if ();

   som_training_step_unit DUT (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [VAL_W-1:0] grid_w0 [NEURONS];
   logic [VAL_W-1:0] grid_w1 [NEURONS];
   bit               grid_written [NEURONS];
   logic [VAL_W-1:0] rate_q = LR_RESET;
   logic [VAL_W-1:0] decay_q = DECAY_RESET;

   request_type  pending_requests [$];
   response_type expected_responses [$];
   int  errors = 0;
   int  responses_seen = 0;
   int  trains_seen = 0;
   longint cycle_count = 0;
   bit  stimulus_done = 1'b0;
   bit  long_hold = 1'b0;
   bit  sender_pause = 1'b0;

   function automatic logic [VAL_W-1:0] step_toward(logic [VAL_W-1:0] w,
                                                    logic [VAL_W-1:0] x,
                                                    logic [VAL_W-1:0] coef);
      logic [47:0] mag;
      if (x >= w) begin
         mag = ((48'(x) - 48'(w)) * 48'(coef)) >> FRAC_BITS;
         return w + mag[VAL_W-1:0];
      end
      mag = ((48'(w) - 48'(x)) * 48'(coef) + 48'(VAL_MASK)) >> FRAC_BITS;
      return w - mag[VAL_W-1:0];
   endfunction

   function automatic logic [33:0] squared_gap(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      logic [VAL_W-1:0] d;
      d = (a >= b) ? a - b : b - a;
      return 34'(d) * 34'(d);
   endfunction

   // apply one request to the local grid and return the response it causes
   function automatic response_type som_predict(request_type rq);
      response_type rs;
      logic [33:0] gap_sum, best;
      logic [47:0] gain, coef;
      int idx, wr, wc, norm;
      rs = '0;
      idx = int'(rq.row) * COLS + int'(rq.col);
      case (rq.operation)
         OP_WRITE: begin
            if (rq.row < ROWS && rq.col < COLS) begin
               grid_w0[idx] = rq.first_component;
               grid_w1[idx] = rq.second_component;
               grid_written[idx] = 1'b1;
            end
         end
         OP_READ: begin
            if (rq.row < ROWS && rq.col < COLS) begin
               rs.read_first = grid_w0[idx];
               rs.read_second = grid_w1[idx];
            end
         end
         OP_TRAIN: begin
            wr = 0; wc = 0; best = 0;
            for (int n = 0; n < NEURONS; n++) begin
               gap_sum = squared_gap(rq.first_component, grid_w0[n]) +
                         squared_gap(rq.second_component, grid_w1[n]);
               if (n == 0 || gap_sum < best) begin
                  best = gap_sum; wr = n / COLS; wc = n % COLS;
               end
            end
            for (int n = 0; n < NEURONS; n++) begin
               norm = (wr - n / COLS) * (wr - n / COLS) + (wc - n % COLS) * (wc - n % COLS);
               gain = 48'd1 << FRAC_BITS;
               for (int k = 0; k < norm && gain != 0; k++)
                  gain = (gain * 48'(decay_q)) >> FRAC_BITS;
               coef = (48'(rate_q) * gain) >> FRAC_BITS;
               grid_w0[n] = step_toward(grid_w0[n], rq.first_component, coef[VAL_W-1:0]);
               grid_w1[n] = step_toward(grid_w1[n], rq.second_component, coef[VAL_W-1:0]);
            end
            rs.winner_row = wr[ADDR_FIELD_W-1:0];
            rs.winner_col = wc[ADDR_FIELD_W-1:0];
            rs.min_distance = best[DIST_W-1:0];
         end
         default: ;
      endcase
      return rs;
   endfunction

   function automatic bit all_written();
      foreach (grid_written[n])
         if (!grid_written[n])
            return 1'b0;
      return 1'b1;
   endfunction

   // driver: bursts with random gaps, predictions made at acceptance
   int gap_left = 0;
   int burst_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.operation <= OP_WRITE;
         req_if.row <= '0;
         req_if.col <= '0;
         req_if.first_component <= '0;
         req_if.second_component <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_responses.push_back(som_predict({req_if.operation, req_if.row,
               req_if.col, req_if.first_component, req_if.second_component}));
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0 || sender_pause || pending_requests.size() == 0) begin
               req_if.valid <= 1'b0;
               if (gap_left > 0)
                  gap_left <= gap_left - 1;
            end else begin
               request_type rq;
               rq = pending_requests.pop_front();
               req_if.valid <= 1'b1;
               {req_if.operation, req_if.row, req_if.col, req_if.first_component,
                req_if.second_component} <= rq;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 8);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // receiver stall pattern, with an optional long hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else if (long_hold)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ((cycle_count / 256) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
   end

   // monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         response_type got, want;
         got = {rsp_if.winner_row, rsp_if.winner_col, rsp_if.min_distance,
                rsp_if.read_first, rsp_if.read_second};
         responses_seen <= responses_seen + 1;
         if (expected_responses.size() == 0) begin
            $error("response with nothing expected");
            errors <= errors + 1;
         end else begin
            want = expected_responses.pop_front();
            if (want.min_distance != 0 || want.winner_row != 0 || want.winner_col != 0)
               trains_seen <= trains_seen + 1;
            if (got.winner_row !== want.winner_row) begin
               $error("winner_row expected %0d got %0d", want.winner_row, got.winner_row);
               errors <= errors + 1;
            end
            if (got.winner_col !== want.winner_col) begin
               $error("winner_col expected %0d got %0d", want.winner_col, got.winner_col);
               errors <= errors + 1;
            end
            if (got.min_distance !== want.min_distance) begin
               $error("min_distance expected %0d got %0d", want.min_distance,
                      got.min_distance);
               errors <= errors + 1;
            end
            if (got.read_first !== want.read_first) begin
               $error("read_first expected %0d got %0d", want.read_first, got.read_first);
               errors <= errors + 1;
            end
            if (got.read_second !== want.read_second) begin
               $error("read_second expected %0d got %0d", want.read_second,
                      got.read_second);
               errors <= errors + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL som_training_step_unit");
         $finish;
      end
   end

   task automatic add_request(op_type op, int r, int c, int a, int b);
      request_type rq;
      rq.operation = op;
      rq.row = r[ADDR_FIELD_W-1:0];
      rq.col = c[ADDR_FIELD_W-1:0];
      rq.first_component = a[VAL_W-1:0];
      rq.second_component = b[VAL_W-1:0];
      pending_requests.push_back(rq);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_if.valid || expected_responses.size() != 0)
         @(posedge clock);
      repeat (TRAIN_CYCLES + 20) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value[VAL_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_LEARNING_RATE)
         rate_q = value[VAL_W-1:0];
      else
         decay_q = value[VAL_W-1:0];
      @(posedge clock);
   endtask

   // fill the whole grid so every later read and train is defined
   task automatic fill_grid();
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < COLS; c++)
            add_request(OP_WRITE, r, c, $urandom_range(0, 65535), $urandom_range(0, 65535));
   endtask

   // random mix; the first phase must stay defined until the grid is full
   task automatic random_phase(int count);
      int pick, r, c;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, ROWS - 1);
         c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, COLS - 1);
         if (pick < 35)
            add_request(OP_WRITE, r, c, $urandom_range(0, 65535), $urandom_range(0, 65535));
         else if (pick < 65)
            add_request(OP_READ, r, c, $urandom_range(0, 65535), $urandom_range(0, 65535));
         else if (pick < 95)
            add_request(OP_TRAIN, $urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
         else
            add_request(op_type'(2'd3), r, c, $urandom_range(0, 65535),
                        $urandom_range(0, 65535));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: grid fill with extremes, out-of-grid, unused op, ties
      fill_grid();
      add_request(OP_WRITE, 0, 0, 0, 0);
      add_request(OP_WRITE, 9, 9, 65535, 65535);
      add_request(OP_WRITE, 0, 1, 0, 0);
      add_request(OP_WRITE, 10, 3, 1234, 4321);
      add_request(OP_WRITE, 15, 15, 65535, 65535);
      add_request(OP_READ, 0, 0, 0, 0);
      add_request(OP_READ, 9, 9, 65535, 65535);
      add_request(OP_READ, 3, 12, 0, 0);
      add_request(op_type'(2'd3), 15, 15, 65535, 65535);
      add_request(OP_TRAIN, 0, 0, 0, 0);
      add_request(OP_TRAIN, 15, 15, 65535, 65535);
      add_request(OP_TRAIN, 0, 0, 32768, 16384);
      add_request(OP_READ, 0, 1, 0, 0);
      wait_drained();

      // extreme settings
      write_csr(CSR_LEARNING_RATE, 65535);
      write_csr(CSR_NEIGHBOUR_DECAY, 65535);
      add_request(OP_TRAIN, 0, 0, 100, 60000);
      add_request(OP_READ, 5, 5, 0, 0);
      random_phase(150);
      // long receiver hold-off while the sender keeps offering
      long_hold = 1'b1;
      repeat (2000) @(posedge clock);
      long_hold = 1'b0;
      wait_drained();

      write_csr(CSR_LEARNING_RATE, 0);
      write_csr(CSR_NEIGHBOUR_DECAY, 0);
      random_phase(150);
      wait_drained();

      write_csr(CSR_LEARNING_RATE, 1);
      write_csr(CSR_NEIGHBOUR_DECAY, 32768);
      fill_grid();
      random_phase(200);
      // sender pauses until every response is back
      sender_pause = 1'b1;
      while (expected_responses.size() != 0 || req_if.valid) @(posedge clock);
      sender_pause = 1'b0;
      wait_drained();

      write_csr(CSR_LEARNING_RATE, $urandom_range(0, 65535));
      write_csr(CSR_NEIGHBOUR_DECAY, $urandom_range(0, 65535));
      random_phase(150);
      wait_drained();

      write_csr(CSR_LEARNING_RATE, LR_RESET);
      write_csr(CSR_NEIGHBOUR_DECAY, DECAY_RESET);
      random_phase(120);
      wait_drained();

      stimulus_done = 1'b1;
      $display("Covered %0d responses, %0d with a nonzero winner or distance,",
               responses_seen, trains_seen);
      $display("over five rate/decay settings including both extremes.");
      if (errors == 0 && expected_responses.size() == 0 && all_written()) begin
         $display("PASS som_training_step_unit");
      end else begin
         $display("FAIL som_training_step_unit");
      end
      $finish;
   end
endmodule

// File: filelist.f
+incdir+hdl
hdl/som_pkg.sv
hdl/som_ifs.sv
hdl/som_ram.sv
hdl/som_dist.sv
hdl/som_move.sv
hdl/som_training_step_unit.sv
verif/som_training_step_unit_test.sv
